// ===== design/sil_pkg.sv =====
package sil_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned PosW         = 4;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DUMP   = 1'b1
  } kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // shared control broadcast along the cell chain
  typedef struct packed {
    logic                     ins;
    logic                     rot;
    logic signed [ValueW-1:0] value;
  } ctl_t;

endpackage

// ===== design/sil_cell.sv =====
module sil_cell (
  input  logic                              clk,
  input  sil_pkg::ctl_t                     ctl,
  input  logic                              is_first,
  input  logic                              valid,
  input  logic                              is_tail,
  input  logic                              left_pass,
  input  logic signed [sil_pkg::ValueW-1:0] left_data,
  input  logic signed [sil_pkg::ValueW-1:0] right_data,
  input  logic signed [sil_pkg::ValueW-1:0] head_data,
  output logic signed [sil_pkg::ValueW-1:0] data,
  output logic                              pass
);
  import sil_pkg::*;

  logic signed [ValueW-1:0] data_next;

  // stored value sits below the new one: entry stays put on insert
  assign pass = valid && (data < ctl.value);

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (!pass) begin
        if (is_first || left_pass) begin
          data_next = ctl.value;
        end else begin
          data_next = left_data;
        end
      end
    end else if (ctl.rot && valid) begin
      // readout rotates the occupied part; the head wraps round to the tail
      data_next = is_tail ? head_data : right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== design/sorted_insertion_list.sv =====
// Insert: one transaction per cycle while the output is free; the result is registered on acceptance.
// Readout of n entries gives n results (one for an empty list), one entry per
// cycle while m_tready is high as the cell chain rotates; no new input is taken until the last is sent.
// Output is held while m_tready is low. Reset empties the list; stored
// values are not cleared.
module sorted_insertion_list #(
  parameter int unsigned DEPTH = sil_pkg::DepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] entry_value, [35:32] position, [39:36] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last
);
  import sil_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] idx, idx_next;

  logic                 out_valid, out_valid_next;
  status_t              out_status, out_status_next;
  logic signed [ValueW-1:0] out_value, out_value_next;
  logic [PosW-1:0]      out_pos, out_pos_next;
  logic                 out_last, out_last_next;

  ctl_t ctl;
  logic signed [ValueW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] pass;
  logic [DEPTH-1:0] valid;
  logic [IW-1:0]    slot;
  logic             out_free;
  logic             accept;
  logic             full;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CW'(i) < count;
    end
  end

  // first cell that does not pass is the insert slot
  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!pass[i] && (i == 0 || pass[(i == 0) ? 0 : i-1])) begin
        slot = slot | IW'(i);
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sil_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .is_first  (g == 0),
        .valid     (valid[g]),
        .is_tail   (valid[g] && ((g == DEPTH-1) || !valid[(g == DEPTH-1) ? g : g+1])),
        .left_pass ((g == 0) ? 1'b0 : pass[(g == 0) ? 0 : g-1]),
        .left_data ((g == 0) ? ctl.value : cell_data[(g == 0) ? 0 : g-1]),
        .right_data((g == DEPTH-1) ? cell_data[g] : cell_data[(g == DEPTH-1) ? g : g+1]),
        .head_data (cell_data[0]),
        .data      (cell_data[g]),
        .pass      (pass[g])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_pos_next    = out_pos;
    out_last_next   = out_last;
    ctl.ins         = 1'b0;
    ctl.rot         = 1'b0;
    ctl.value       = $signed(s_tdata);

    if (out_free) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          out_last_next  = 1'b1;
          if (kind_t'(s_tuser) == KIND_INSERT) begin
            out_value_next = $signed(s_tdata);
            if (full) begin
              out_status_next = ST_FULL;
              out_pos_next    = '0;
            end else begin
              ctl.ins         = 1'b1;
              out_status_next = ST_INSERTED;
              out_pos_next    = PosW'(slot);
              count_next      = count + CW'(1);
            end
          end else if (count == '0) begin
            out_status_next = ST_EMPTY;
            out_value_next  = '0;
            out_pos_next    = '0;
          end else begin
            // first entry goes out now, the rest follow in S_DUMP
            ctl.rot         = 1'b1;
            out_status_next = ST_ENTRY;
            out_value_next  = cell_data[0];
            out_pos_next    = '0;
            out_last_next   = (count == CW'(1));
            idx_next        = IW'(1);
            if (count != CW'(1)) begin
              state_next = S_DUMP;
            end
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.rot         = 1'b1;
          out_valid_next  = 1'b1;
          out_status_next = ST_ENTRY;
          out_value_next  = cell_data[0];
          out_pos_next    = PosW'(idx);
          out_last_next   = (CW'(idx) + CW'(1) == count);
          idx_next        = idx + IW'(1);
          if (CW'(idx) + CW'(1) == count) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_pos    <= out_pos_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_pos, out_value};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

// ===== tb/sorted_insertion_list_tb.sv =====
module sorted_insertion_list_tb;
  import sil_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 420;

  // Mirror of the list contents; works out every result the block owes.
  class sorted_list_checker;
    typedef struct {
      status_t           status;
      logic [ValueW-1:0] value;
      logic [PosW-1:0]   pos;
      logic              last;
    } beat_t;

    logic signed [ValueW-1:0] held_vals[$];
    beat_t                    awaited[$];
    int unsigned              mismatches = 0;

    function void note_request(kind_t k, logic [ValueW-1:0] v);
      int unsigned slot;
      beat_t       b;
      if (k == KIND_INSERT) begin
        b.value = v;
        b.last  = 1'b1;
        if (held_vals.size() >= DepthDefault) begin
          b.status = ST_FULL;
          b.pos    = '0;
        end else begin
          // new value goes ahead of any equal ones already held
          slot = held_vals.size();
          for (int i = 0; i < held_vals.size(); i++) begin
            if (held_vals[i] >= $signed(v)) begin
              slot = i;
              break;
            end
          end
          held_vals.insert(slot, v);
          b.status = ST_INSERTED;
          b.pos    = PosW'(slot);
        end
        awaited.push_back(b);
      end else if (held_vals.size() == 0) begin
        b.status = ST_EMPTY;
        b.value  = '0;
        b.pos    = '0;
        b.last   = 1'b1;
        awaited.push_back(b);
      end else begin
        for (int i = 0; i < held_vals.size(); i++) begin
          b.status = ST_ENTRY;
          b.value  = held_vals[i];
          b.pos    = PosW'(i);
          b.last   = (i == held_vals.size() - 1);
          awaited.push_back(b);
        end
      end
    endfunction

    function void check_result(logic [StatusW-1:0] st, logic [ValueW-1:0] v,
                               logic [PosW-1:0] p, logic l);
      beat_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transaction: status %0d value %0d pos %0d last %0d",
                   $realtime, st, $signed(v), p, l);
      end else begin
        e = awaited.pop_front();
        if (st !== e.status || v !== e.value || p !== e.pos || l !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: exp status %0d value %0d pos %0d last %0d,",
                     $realtime, e.status, $signed(e.value), e.pos, e.last,
                     " got status %0d value %0d pos %0d last %0d",
                     st, $signed(v), p, l);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] entry_value, [35:32] position, [39:36] zero
  logic [1:0]  m_tuser;        // [1:0] status
  logic        m_tlast;

  sorted_list_checker chk = new();
  int unsigned        idle_cycles = 0;

  always #5 clk = ~clk;

  sorted_insertion_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        chk.check_result(m_tuser, m_tdata[31:0], m_tdata[35:32], m_tlast);
      if (s_tvalid && s_tready)
        chk.note_request(kind_t'(s_tuser), s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // bias towards duplicates, sign boundaries and the extremes
  function automatic logic [31:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 5) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_item(input kind_t k, input logic [31:0] v, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : random_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // receiver: random back-pressure with bursts of readiness
  initial begin
    @(negedge rst);
    forever begin
      int unsigned g;
      g = random_gap();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    kind_t k;
    bit    calm;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty readout, extremes, signed ordering and ties
    send_item(KIND_DUMP,   $urandom(),   1'b0);
    send_item(KIND_INSERT, 32'h0000_0000, 1'b0);
    send_item(KIND_INSERT, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_INSERT, 32'h8000_0000, 1'b0);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_INSERT, 32'h0000_0001, 1'b1);
    send_item(KIND_INSERT, 32'h0000_0000, 1'b1);
    send_item(KIND_INSERT, 32'h8000_0000, 1'b1);
    send_item(KIND_INSERT, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_DUMP,   $urandom(),   1'b0);
    drain_results();

    // list fills up here; later inserts exercise the rejection path
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 140 == 139)
        drain_results();
      calm = (n % 100) < 20;
      k = ($urandom_range(0, 4) == 0) ? KIND_DUMP : KIND_INSERT;
      send_item(k, rand_value(), calm);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
    repeat (10) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
